// ===== hw/rtl/ssrq_pkg.sv =====
// Shared constants and types for the sorted store with rank query.
package ssrq_pkg;

  localparam int CAPACITY = 256;
  localparam int VAL_W    = 32;
  localparam int RANK_W   = 9;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OUT_DW   = ((VAL_W + RANK_W + 7) / 8) * 8;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANK_OVER = 2'd2
  } status_t;

  typedef struct packed {
    logic                    en;
    logic signed [VAL_W-1:0] value;
  } ins_t;

endpackage

// ===== hw/rtl/ssrq_cell.sv =====
// One compare-and-shift cell of the sorted chain.
module ssrq_cell (
  input  logic                             clk,
  input  ssrq_pkg::ins_t                   ins,
  input  logic                             occupied,
  input  logic                             prev_gt,
  input  logic signed [ssrq_pkg::VAL_W-1:0] prev_value,
  output logic                             gt,
  output logic signed [ssrq_pkg::VAL_W-1:0] value
);
  import ssrq_pkg::*;

  logic signed [VAL_W-1:0] value_r;

  assign value = value_r;
  assign gt    = !occupied || (value_r > ins.value);

  always_ff @(posedge clk) begin
    if (ins.en && gt) begin
      value_r <= prev_gt ? prev_value : ins.value;
    end
  end

endmodule

// ===== hw/rtl/sorted_store_rank_query.sv =====
// Sorted store with rank query: top level with cell chain and output stage.
//
// Input channel (in_*): in_tuser carries the kind (0 add, 1 get), in_tdata
// the signed 32-bit value. Output channel (out_*): one result item per
// input item; out_tdata holds found_value and rank_used, out_tuser the
// status (0 ok, 1 store full, 2 rank beyond count).
// An add item is inserted in order by a chain of 256 compare-and-shift
// cells in the cycle it is accepted; a get item reads the cell at the
// running rank through a select and advances the rank on success.
// The result is registered, and out_tvalid rises in the cycle after accept. Throughput is one item
// per cycle: the single output register is refilled in the cycle it is
// taken, so in_tready stays high while out_tready is high.
// When the receiver stalls, the result holds in the output register and
// in_tready drops until it is taken.
// Reset (rst_n low, synchronous) empties the store, sets the rank counter
// to one and drops out_tvalid; cell contents are left as they are and are
// not read before they are written again. No clearing pass is needed.
module sorted_store_rank_query (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ssrq_pkg::VAL_W-1:0] in_tdata,   // [31:0] value
  input  logic                       in_tuser,   // [0] kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ssrq_pkg::OUT_DW-1:0] out_tdata, // [31:0] found_value, [40:32] rank_used
  output logic [ssrq_pkg::STAT_W-1:0] out_tuser  // [1:0] status
);
  import ssrq_pkg::*;

  logic                    accept;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        rank_r;
  logic [CNT_W-1:0]        rank_nxt;
  logic [IDX_W-1:0]        rd_idx;
  logic                    full;
  logic                    rank_over;
  ins_t                    ins;
  logic                    gt    [CAPACITY];
  logic signed [VAL_W-1:0] cells [CAPACITY];

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [RANK_W-1:0]       out_rank_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_nxt;
  logic [RANK_W-1:0]       out_rank_nxt;
  status_t                 out_status_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign rank_over = (rank_r > count_r);
  assign rd_idx    = IDX_W'(rank_r - CNT_W'(1));

  assign ins.en    = accept && (in_tuser == KIND_ADD) && !full;
  assign ins.value = in_tdata;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      ssrq_cell u_cell (
        .clk        (clk),
        .ins        (ins),
        .occupied   (count_r > CNT_W'(i)),
        .prev_gt    (1'b0),
        .prev_value (ins.value),
        .gt         (gt[i]),
        .value      (cells[i])
      );
    end else begin : g_body
      ssrq_cell u_cell (
        .clk        (clk),
        .ins        (ins),
        .occupied   (count_r > CNT_W'(i)),
        .prev_gt    (gt[i-1]),
        .prev_value (cells[i-1]),
        .gt         (gt[i]),
        .value      (cells[i])
      );
    end
  end

  always_comb begin
    count_nxt      = count_r;
    rank_nxt       = rank_r;
    out_value_nxt  = '0;
    out_rank_nxt   = '0;
    out_status_nxt = ST_OK;
    if (in_tuser == KIND_ADD) begin
      if (full) begin
        out_status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      out_rank_nxt = RANK_W'(rank_r);
      if (rank_over) begin
        out_status_nxt = ST_RANK_OVER;
      end else begin
        out_value_nxt = cells[rd_idx];
        rank_nxt      = rank_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rank_r      <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        rank_r  <= rank_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_rank_r   <= out_rank_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - VAL_W - RANK_W){1'b0}}, out_rank_r, out_value_r};
  assign out_tuser  = out_status_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_rank_bound : assert property (@(posedge clk) disable iff (!rst_n)
    rank_r != '0 && rank_r <= count_r + CNT_W'(1))
    else $error("rank counter out of range");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_FULL ||
                     out_status_r == ST_RANK_OVER))
    else $error("bad status on result");

  a_get_ok_advances : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == KIND_GET && !rank_over |=> rank_r == $past(rank_r) + CNT_W'(1))
    else $error("rank did not advance after successful get");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sorted store with rank query: directed table, then random traffic.
module testbench;
  import ssrq_pkg::*;

  localparam int RAND_ITEMS   = 1300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_DEPTH    = 32;
  localparam int PEND_DEPTH   = 2048;

  typedef struct packed {
    logic signed [VAL_W-1:0]  found;
    logic        [RANK_W-1:0] rank;
    status_t                  status;
  } query_result_t;

  typedef struct {
    logic             kind;
    logic [VAL_W-1:0] value;
    bit               typed;
    query_result_t    want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [VAL_W-1:0]    in_tdata;   // [31:0] value
  logic                in_tuser;   // [0] kind
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // [31:0] found_value, [40:32] rank_used
  logic [STAT_W-1:0]   out_tuser;  // [1:0] status

  logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
  int                      shadow_count;
  int                      shadow_rank;
  query_result_t           pending_results [PEND_DEPTH];
  int                      pend_wr;
  int                      pend_rd;
  dir_row_t                dir_rows [DIR_DEPTH];
  int                      dir_count;
  int                      mismatches;
  bit                      no_idle;

  sorted_store_rank_query dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void add_row(input dir_row_t row);
    dir_rows[dir_count] = row;
    dir_count++;
  endfunction

  function automatic void pend_store(input query_result_t r);
    pending_results[pend_wr % PEND_DEPTH] = r;
    pend_wr++;
  endfunction

  function automatic query_result_t pend_take();
    query_result_t r;
    r = pending_results[pend_rd % PEND_DEPTH];
    pend_rd++;
    return r;
  endfunction

  function automatic query_result_t apply_store_item(input logic kind,
                                                     input logic signed [VAL_W-1:0] val);
    query_result_t r;
    int            pos;
    r.found  = '0;
    r.rank   = '0;
    r.status = ST_OK;
    if (kind == KIND_ADD) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_vals[pos] < val) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = val;
        shadow_count++;
      end
    end else begin
      r.rank = RANK_W'(shadow_rank);
      if (shadow_rank == 0 || shadow_rank > shadow_count) begin
        r.status = ST_RANK_OVER;
      end else begin
        r.found = shadow_vals[shadow_rank-1];
        shadow_rank++;
      end
    end
    return r;
  endfunction

  task automatic drive_item(input logic kind, input logic [VAL_W-1:0] val,
                            input bit typed, input query_result_t want);
    int            gap;
    query_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_store_item(kind, val);
    pend_store(typed ? want : predicted);
  endtask

  initial begin : result_sink
    int            stall;
    query_result_t want;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (pend_wr == pend_rd) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result item: found=%0d rank=%0d status=%0d",
                   $signed(out_tdata[VAL_W-1:0]), out_tdata[VAL_W+RANK_W-1:VAL_W], out_tuser);
      end else begin
        want = pend_take();
        if (out_tdata[VAL_W-1:0] !== want.found ||
            out_tdata[VAL_W+RANK_W-1:VAL_W] !== want.rank ||
            out_tuser !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"mismatch: expected found=%0d rank=%0d status=%0d, ",
                      "got found=%0d rank=%0d status=%0d"},
                     want.found, want.rank, want.status, $signed(out_tdata[VAL_W-1:0]),
                     out_tdata[VAL_W+RANK_W-1:VAL_W], out_tuser);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic             kind;
    logic [VAL_W-1:0] val;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= KIND_ADD;
    out_tready   <= 1'b0;
    mismatches   = 0;
    no_idle      = 1'b0;
    shadow_count = 0;
    shadow_rank  = 1;
    pend_wr      = 0;
    pend_rd      = 0;
    dir_count    = 0;

    add_row(dir_row_t'{KIND_GET, 32'h0000_0000, 1'b1, '{32'sh0, 9'd1, ST_RANK_OVER}});
    add_row(dir_row_t'{KIND_GET, 32'hFFFF_FFFF, 1'b1, '{32'sh0, 9'd1, ST_RANK_OVER}});
    add_row(dir_row_t'{KIND_ADD, 32'h8000_0000, 1'b1, '{32'sh0, 9'd0, ST_OK}});
    add_row(dir_row_t'{KIND_GET, 32'h0000_0000, 1'b1, '{32'sh8000_0000, 9'd1, ST_OK}});
    add_row(dir_row_t'{KIND_GET, 32'h1234_5678, 1'b1, '{32'sh0, 9'd2, ST_RANK_OVER}});
    add_row(dir_row_t'{KIND_ADD, 32'h7FFF_FFFF, 1'b1, '{32'sh0, 9'd0, ST_OK}});
    add_row(dir_row_t'{KIND_ADD, 32'h0000_0000, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'hFFFF_FFFF, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h0000_0001, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h0000_0005, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h0000_0005, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h0000_0005, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h8000_0000, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h7FFF_FFFF, 1'b0, '0});
    for (int i = 0; i < 8; i++) add_row(dir_row_t'{KIND_GET, 32'hFFFF_FFFF, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'h5A5A_5A5A, 1'b0, '0});
    add_row(dir_row_t'{KIND_ADD, 32'hA5A5_A5A5, 1'b0, '0});
    add_row(dir_row_t'{KIND_GET, 32'h0000_0000, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_count; i++)
      drive_item(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (shadow_count < CAPACITY) kind = ($urandom_range(0, 99) < 52) ? KIND_ADD : KIND_GET;
      else kind = ($urandom_range(0, 99) < 15) ? KIND_ADD : KIND_GET;
      case ($urandom_range(0, 9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2, 3, 4: val = int'($urandom_range(0, 15)) - 8;
        default: val = $urandom;
      endcase
      drive_item(kind, val, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ssrq_pkg.sv
hw/rtl/ssrq_cell.sv
hw/rtl/sorted_store_rank_query.sv
sim/testbench.sv
